FILE: src/svg_pkg.sv
// ----------------------------------------------------------------------------
// svg_pkg
// shared types, register indexes and the cordic angle table
// ----------------------------------------------------------------------------
package svg_pkg;

    localparam logic [1:0] REG_RADIUS  = 2'd0;
    localparam logic [1:0] REG_SECTORS = 2'd1;
    localparam logic [1:0] REG_STACKS  = 2'd2;

    localparam logic [10:0] MIN_SECTORS = 11'd3;
    localparam logic [10:0] MIN_STACKS  = 11'd2;
    localparam int          ATAN_LEN    = 24;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sh026DD3B6A;

    // one grid point with its effective counts
    typedef struct packed {
        logic [10:0] st;
        logic [10:0] se;
        logic [10:0] ns;
        logic [10:0] nt;
    } svg_item_t;

    function automatic logic [31:0] atan_turn(input int unsigned i);
        logic [31:0] a;
        case (i)
            0:  a = 32'h20000000;
            1:  a = 32'h12E4051E;
            2:  a = 32'h09FB385B;
            3:  a = 32'h051111D4;
            4:  a = 32'h028B0D43;
            5:  a = 32'h0145D7E1;
            6:  a = 32'h00A2F61E;
            7:  a = 32'h00517C55;
            8:  a = 32'h0028BE53;
            9:  a = 32'h00145F2F;
            10: a = 32'h000A2F98;
            11: a = 32'h000517CC;
            12: a = 32'h00028BE6;
            13: a = 32'h000145F3;
            14: a = 32'h0000A2FA;
            15: a = 32'h0000517D;
            16: a = 32'h000028BE;
            17: a = 32'h0000145F;
            18: a = 32'h00000A30;
            19: a = 32'h00000518;
            20: a = 32'h0000028C;
            21: a = 32'h00000146;
            22: a = 32'h000000A3;
            23: a = 32'h00000051;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

FILE: src/sphere_vertex_generator_unit.sv
// ----------------------------------------------------------------------------
// sphere_vertex_generator_unit
// one uv sphere vertex (position, normal, texture) per grid point
// ----------------------------------------------------------------------------
// A grid point is taken on any cycle with start high and busy low; one
// transaction per clock is sustained. Each result appears on done for one
// cycle, after passing through the bit-per-stage phase dividers, a phase
// stage, one cordic stage per step plus a fold stage, and four stages of
// products and rounding. The receiver cannot stall, so the back end drains
// the queue every cycle and busy stays low in normal use. Registers are to
// be written with wr_en only while idle; the block itself does not enforce it.
module sphere_vertex_generator_unit #(
    parameter int MAX_SEGMENTS = 1024,
    parameter int CORDIC_STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [1:0]         wr_index,
    input  logic [15:0]        wr_data,
    input  logic               start,
    output logic               busy,
    input  logic [10:0]        stack_index,
    input  logic [10:0]        sector_index,
    output logic               done,
    output logic signed [16:0] pos_x,
    output logic signed [16:0] pos_y,
    output logic signed [16:0] pos_z,
    output logic signed [15:0] norm_x,
    output logic signed [15:0] norm_y,
    output logic signed [15:0] norm_z,
    output logic [16:0]        tex_u,
    output logic [16:0]        tex_v
);
    import svg_pkg::*;

    logic [15:0] radius_reg;
    logic [10:0] sectors_reg;
    logic [10:0] stacks_reg;

    logic        push;
    logic        full;
    logic        empty;
    svg_item_t   front_item;
    svg_item_t   back_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg  <= 16'd256;
            sectors_reg <= 11'd36;
            stacks_reg  <= 11'd18;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_RADIUS:  radius_reg  <= wr_data;
                REG_SECTORS: sectors_reg <= wr_data[10:0];
                REG_STACKS:  stacks_reg  <= wr_data[10:0];
                default:     ;
            endcase
        end
    end

    svg_front #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_front (
        .start        (start),
        .full         (full),
        .stack_index  (stack_index),
        .sector_index (sector_index),
        .sector_count (sectors_reg),
        .stack_count  (stacks_reg),
        .push         (push),
        .item         (front_item)
    );

    svg_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_item),
        .pop   (!empty),
        .rdata (back_item),
        .full  (full),
        .empty (empty)
    );

    svg_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (!empty),
        .item     (back_item),
        .radius   (radius_reg),
        .done     (done),
        .pos_x    (pos_x),
        .pos_y    (pos_y),
        .pos_z    (pos_z),
        .norm_x   (norm_x),
        .norm_y   (norm_y),
        .norm_z   (norm_z),
        .tex_u    (tex_u),
        .tex_v    (tex_v)
    );

    assign busy = full;

endmodule

FILE: src/svg_front.sv
// ----------------------------------------------------------------------------
// svg_front
// takes requests, clamps counts and indices, and pushes them to the queue
// ----------------------------------------------------------------------------
module svg_front #(
    parameter int MAX_SEGMENTS = 1024
) (
    input  logic              start,
    input  logic              full,
    input  logic [10:0]       stack_index,
    input  logic [10:0]       sector_index,
    input  logic [10:0]       sector_count,
    input  logic [10:0]       stack_count,
    output logic              push,
    output svg_pkg::svg_item_t item
);
    import svg_pkg::*;

    localparam int          CAP   = (MAX_SEGMENTS > 2047) ? 2047 : MAX_SEGMENTS;
    localparam logic [10:0] CAP_L = 11'(CAP);

    logic [10:0] ns_cap;
    logic [10:0] nt_cap;

    always_comb
    begin
        ns_cap  = (sector_count > CAP_L) ? CAP_L : sector_count;
        nt_cap  = (stack_count > CAP_L) ? CAP_L : stack_count;
        item.ns = (ns_cap < MIN_SECTORS) ? MIN_SECTORS : ns_cap;
        item.nt = (nt_cap < MIN_STACKS) ? MIN_STACKS : nt_cap;
        item.se = (sector_index > item.ns) ? item.ns : sector_index;
        item.st = (stack_index > item.nt) ? item.nt : stack_index;
    end

    assign push = start && !full;

endmodule

FILE: src/svg_queue.sv
// ----------------------------------------------------------------------------
// svg_queue
// two-entry queue between the front and the back
// ----------------------------------------------------------------------------
module svg_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  svg_pkg::svg_item_t wdata,
    input  logic               pop,
    output svg_pkg::svg_item_t rdata,
    output logic               full,
    output logic               empty
);
    import svg_pkg::*;

    svg_item_t   mem [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    assign rdata = mem[rd_ptr_reg];
    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);

endmodule

FILE: src/svg_div.sv
// ----------------------------------------------------------------------------
// svg_div
// pipelined long division idx/n, one quotient bit a stage, rounded at two points
// ----------------------------------------------------------------------------
module svg_div #(
    parameter int LO_BITS = 32
) (
    input  logic                 clk,
    input  logic [10:0]          idx,
    input  logic [10:0]          n,
    output logic [16:0]          q_hi,
    output logic [LO_BITS:0]     q_lo
);
    localparam int FRAC    = 32;
    localparam int HI_BITS = 16;

    logic [10:0]        rem_reg [FRAC+1];
    logic [FRAC:0]      quo_reg [FRAC+1];
    logic [10:0]        n_reg   [FRAC+1];
    logic [16:0]        hi_reg  [FRAC+1];
    logic [LO_BITS:0]   lo_reg  [FRAC+1];

    // integer stage: idx never exceeds n
    always_ff @(posedge clk)
    begin
        rem_reg[0] <= (idx >= n) ? idx - n : idx;
        quo_reg[0] <= (FRAC+1)'(idx >= n);
        n_reg[0]   <= n;
        hi_reg[0]  <= '0;
        lo_reg[0]  <= '0;
    end

    for (genvar k = 1; k <= FRAC; k++)
    begin : g_stage
        logic [11:0]   r2;
        logic          qb;
        logic [10:0]   rem_next;
        logic [FRAC:0] quo_next;
        logic [10:0]   half;

        always_comb
        begin
            r2       = {rem_reg[k-1], 1'b0};
            qb       = (r2 >= {1'b0, n_reg[k-1]});
            rem_next = qb ? 11'(r2 - {1'b0, n_reg[k-1]}) : r2[10:0];
            quo_next = {quo_reg[k-1][FRAC-1:0], qb};
            half     = 11'(({1'b0, n_reg[k-1]} + 12'd1) >> 1);
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= rem_next;
            quo_reg[k] <= quo_next;
            n_reg[k]   <= n_reg[k-1];
            if (k == HI_BITS)
            begin
                hi_reg[k] <= quo_next[16:0] + 17'(rem_next >= half);
            end
            else
            begin
                hi_reg[k] <= hi_reg[k-1];
            end
            if (k == LO_BITS)
            begin
                lo_reg[k] <= quo_next[LO_BITS:0] + (LO_BITS+1)'(rem_next >= half);
            end
            else
            begin
                lo_reg[k] <= lo_reg[k-1];
            end
        end
    end

    assign q_hi = hi_reg[FRAC];
    assign q_lo = lo_reg[FRAC];

endmodule

FILE: src/svg_cordic.sv
// ----------------------------------------------------------------------------
// svg_cordic
// pipelined rotation cordic, phase in binary turns to cos and sin in q1.30
// ----------------------------------------------------------------------------
module svg_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               clk,
    input  logic [31:0]        phase,
    output logic signed [31:0] cos_q,
    output logic signed [31:0] sin_q
);
    import svg_pkg::*;

    localparam int N = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;

    logic signed [33:0] x_reg [N+1];
    logic signed [33:0] y_reg [N+1];
    logic signed [33:0] z_reg [N+1];
    logic               flip_reg [N+1];

    logic signed [33:0] z0;
    logic signed [33:0] z_fold;
    logic               flip0;

    // fold into the right half plane, undo with a negation at the end
    always_comb
    begin
        z0     = {{2{phase[31]}}, phase};
        flip0  = 1'b0;
        z_fold = z0;
        if (z0 > 34'sd1073741824)
        begin
            z_fold = z0 - 34'sd2147483648;
            flip0  = 1'b1;
        end
        else if (z0 < -34'sd1073741824)
        begin
            z_fold = z0 + 34'sd2147483648;
            flip0  = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]    <= CORDIC_GAIN;
        y_reg[0]    <= '0;
        z_reg[0]    <= z_fold;
        flip_reg[0] <= flip0;
    end

    for (genvar i = 0; i < N; i++)
    begin : g_step
        localparam logic signed [33:0] ATAN = $signed({2'b00, atan_turn(i)});

        always_ff @(posedge clk)
        begin
            flip_reg[i+1] <= flip_reg[i];
            if (z_reg[i] >= 0)
            begin
                x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] - ATAN;
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] + ATAN;
            end
        end
    end

    assign cos_q = flip_reg[N] ? 32'(-x_reg[N]) : x_reg[N][31:0];
    assign sin_q = flip_reg[N] ? 32'(-y_reg[N]) : y_reg[N][31:0];

endmodule

FILE: src/svg_back.sv
// ----------------------------------------------------------------------------
// svg_back
// vertex pipeline: phases by division, sine and cosine, products and rounding
// ----------------------------------------------------------------------------
module svg_back #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  svg_pkg::svg_item_t item,
    input  logic [15:0]        radius,
    output logic               done,
    output logic signed [16:0] pos_x,
    output logic signed [16:0] pos_y,
    output logic signed [16:0] pos_z,
    output logic signed [15:0] norm_x,
    output logic signed [15:0] norm_y,
    output logic signed [15:0] norm_z,
    output logic [16:0]        tex_u,
    output logic [16:0]        tex_v
);
    import svg_pkg::*;

    localparam int N   = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
    localparam int LAT = 39 + N;

    logic [LAT-1:0] vld_reg;

    logic [16:0] se_hi;
    logic [32:0] se_lo;
    logic [16:0] st_hi;
    logic [31:0] st_lo;

    logic [31:0] ph_se_reg;
    logic [31:0] ph_st_reg;
    logic [16:0] tu_reg [N+5];
    logic [16:0] tv_reg [N+5];

    logic signed [31:0] cst;
    logic signed [31:0] sst;
    logic signed [31:0] cse;
    logic signed [31:0] sse;

    logic signed [63:0] pxx_reg;
    logic signed [63:0] pxy_reg;
    logic signed [31:0] uz_reg;
    logic signed [31:0] u_reg [3];
    logic signed [48:0] m_reg [3];
    logic signed [15:0] nr_reg [3];
    logic signed [16:0] p_reg [3];

    logic signed [31:0] u_next [3];
    logic signed [15:0] nr_next [3];
    logic signed [16:0] p_next [3];
    logic signed [31:0] nr_wide [3];
    logic signed [48:0] p_wide [3];

    svg_div #(.LO_BITS(32)) u_div_se (
        .clk  (clk),
        .idx  (item.se),
        .n    (item.ns),
        .q_hi (se_hi),
        .q_lo (se_lo)
    );

    svg_div #(.LO_BITS(31)) u_div_st (
        .clk  (clk),
        .idx  (item.st),
        .n    (item.nt),
        .q_hi (st_hi),
        .q_lo (st_lo)
    );

    always_ff @(posedge clk)
    begin
        ph_se_reg <= se_lo[31:0];
        ph_st_reg <= 32'h40000000 - st_lo;
        tu_reg[0] <= se_hi;
        tv_reg[0] <= st_hi;
    end

    // texture rides alongside the cordic
    for (genvar d = 1; d < N + 5; d++)
    begin : g_tex
        always_ff @(posedge clk)
        begin
            tu_reg[d] <= tu_reg[d-1];
            tv_reg[d] <= tv_reg[d-1];
        end
    end

    svg_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic_st (
        .clk   (clk),
        .phase (ph_st_reg),
        .cos_q (cst),
        .sin_q (sst)
    );

    svg_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic_se (
        .clk   (clk),
        .phase (ph_se_reg),
        .cos_q (cse),
        .sin_q (sse)
    );

    always_comb
    begin
        u_next[0] = 32'((pxx_reg + 64'sd536870912) >>> 30);
        u_next[1] = 32'((pxy_reg + 64'sd536870912) >>> 30);
        u_next[2] = uz_reg;
        for (int k = 0; k < 3; k++)
        begin
            nr_wide[k] = (u_reg[k] + 32'sd32768) >>> 16;
            if (nr_wide[k] > 32'sd16384)
            begin
                nr_next[k] = 16'sd16384;
            end
            else if (nr_wide[k] < -32'sd16384)
            begin
                nr_next[k] = -16'sd16384;
            end
            else
            begin
                nr_next[k] = nr_wide[k][15:0];
            end
            p_wide[k] = (m_reg[k] + 49'sd536870912) >>> 30;
            if (p_wide[k] > 49'sd65535)
            begin
                p_next[k] = 17'sd65535;
            end
            else if (p_wide[k] < -49'sd65535)
            begin
                p_next[k] = -17'sd65535;
            end
            else
            begin
                p_next[k] = p_wide[k][16:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pxx_reg <= cst * cse;
        pxy_reg <= cst * sse;
        uz_reg  <= sst;
        for (int k = 0; k < 3; k++)
        begin
            u_reg[k]  <= u_next[k];
            m_reg[k]  <= $signed({1'b0, radius}) * u_reg[k];
            nr_reg[k] <= nr_next[k];
            p_reg[k]  <= p_next[k];
        end
        norm_x <= nr_reg[0];
        norm_y <= nr_reg[1];
        norm_z <= nr_reg[2];
        tex_u  <= tu_reg[N+4];
        tex_v  <= tv_reg[N+4];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    assign pos_x = p_reg[0];
    assign pos_y = p_reg[1];
    assign pos_z = p_reg[2];
    assign done  = vld_reg[LAT-1];

endmodule

FILE: src/svg_checker.sv
// ----------------------------------------------------------------------------
// svg_checker
// port-level checks on the vertex generator, bound to the top level
// ----------------------------------------------------------------------------
module svg_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               wr_en,
    input logic [1:0]         wr_index,
    input logic [15:0]        wr_data,
    input logic               start,
    input logic               busy,
    input logic [10:0]        stack_index,
    input logic [10:0]        sector_index,
    input logic               done,
    input logic signed [16:0] pos_x,
    input logic signed [16:0] pos_y,
    input logic signed [16:0] pos_z,
    input logic signed [15:0] norm_x,
    input logic signed [15:0] norm_y,
    input logic signed [15:0] norm_z,
    input logic [16:0]        tex_u,
    input logic [16:0]        tex_v
);

    // the back end drains every cycle, so the queue never fills
    assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("queue filled up");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (norm_x >= -16'sd16384) && (norm_x <= 16'sd16384)
              && (norm_y >= -16'sd16384) && (norm_y <= 16'sd16384)
              && (norm_z >= -16'sd16384) && (norm_z <= 16'sd16384))
        else $error("normal out of unit range");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (pos_x != -17'sd65536) && (pos_y != -17'sd65536)
              && (pos_z != -17'sd65536))
        else $error("position not saturated");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (tex_u <= 17'd65536) && (tex_v <= 17'd65536))
        else $error("texture coordinate above one");

endmodule

bind sphere_vertex_generator_unit svg_checker u_svg_checker (.*);
